// File: hdl/vmc_pkg.sv
// Package for the 2-D vector length clamp.
// Holds the input and result transfer types; depends on nothing.
package vmc_pkg;

  typedef struct packed {
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic [30:0]        limit;
  } vmc_in_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic               clamped;
  } vmc_out_t;

  // One pipeline slot of the square root and divider sections.
  typedef struct packed {
    logic        valid;
    logic [31:0] xr;
    logic [31:0] yr;
    logic        clamp;
    logic [63:0] rem;
    logic [31:0] root;
    logic [63:0] nx;
    logic [63:0] ny;
    logic [31:0] qx;
    logic [31:0] qy;
  } vmc_slot_t;

endpackage

// File: hdl/vector_magnitude_clamp_2d.sv
// Top level of the 2-D vector length clamp: a fully pipelined datapath.
// Depends on vmc_pkg for the transfer and pipeline slot types.
//
// A vector is taken in every cycle (busy stays low) and its result is
// strobed on done, in order. The pipeline is made of the input
// register with magnitudes, one product stage, one compare stage,
// 32 stages of the bit-per-stage square root and 32 stages of the two
// restoring dividers. The receiver cannot stall the pipeline.
module vector_magnitude_clamp_2d (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  vmc_pkg::vmc_in_t  in_item,
  output logic              done,
  output vmc_pkg::vmc_out_t result
);
  import vmc_pkg::*;

  localparam int Steps = 32;

  // Front end: input register with magnitudes.
  logic        v1;
  logic [31:0] xr1, yr1, mx1, my1;
  logic [30:0] lim1;
  // Squares and scaled products.
  logic        v2;
  logic [31:0] xr2, yr2;
  logic [63:0] sqx2, sqy2, limsq2, px2, py2;

  vmc_slot_t sq [0:Steps];
  vmc_slot_t dv [0:Steps];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
    end
    xr1    <= in_item.x_in;
    yr1    <= in_item.y_in;
    mx1    <= in_item.x_in[31] ? 32'(-in_item.x_in) : in_item.x_in;
    my1    <= in_item.y_in[31] ? 32'(-in_item.y_in) : in_item.y_in;
    lim1   <= in_item.limit;
    xr2    <= xr1;
    yr2    <= yr1;
    sqx2   <= 64'(mx1) * 64'(mx1);
    sqy2   <= 64'(my1) * 64'(my1);
    limsq2 <= 64'(lim1) * 64'(lim1);
    px2    <= 64'(mx1) * 64'(lim1);
    py2    <= 64'(my1) * 64'(lim1);
  end

  // The sum of squares is at most 2^63, so it fits unsigned 64 bits.
  logic [63:0] sum2;
  assign sum2 = sqx2 + sqy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].valid <= 1'b0;
    end else begin
      sq[0].valid <= v2;
    end
    sq[0].xr    <= xr2;
    sq[0].yr    <= yr2;
    sq[0].clamp <= sum2 > limsq2;
    sq[0].rem   <= sum2;
    sq[0].root  <= '0;
    sq[0].nx    <= px2;
    sq[0].ny    <= py2;
    sq[0].qx    <= '0;
    sq[0].qy    <= '0;
  end

  // Square root: each stage decides one root bit, rem holds sum - root^2.
  for (genvar i = 0; i < Steps; i++) begin : g_sqrt
    localparam int K = Steps - 1 - i;
    logic [63:0] test;
    vmc_slot_t   nxt;
    always_comb begin
      test = (64'(sq[i].root) << (K + 1)) + (64'd1 << (2 * K));
      nxt  = sq[i];
      if (sq[i].rem >= test) begin
        nxt.rem     = sq[i].rem - test;
        nxt.root[K] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq[i+1].valid <= 1'b0;
      end else begin
        sq[i+1].valid <= sq[i].valid;
      end
      sq[i+1].xr    <= nxt.xr;
      sq[i+1].yr    <= nxt.yr;
      sq[i+1].clamp <= nxt.clamp;
      sq[i+1].rem   <= nxt.rem;
      sq[i+1].root  <= nxt.root;
      sq[i+1].nx    <= nxt.nx;
      sq[i+1].ny    <= nxt.ny;
      sq[i+1].qx    <= nxt.qx;
      sq[i+1].qy    <= nxt.qy;
    end
  end

  // A zero root means the vector passes unchanged.
  always_comb begin
    dv[0]       = sq[Steps];
    dv[0].clamp = sq[Steps].clamp && (sq[Steps].root != '0);
  end

  // Restoring dividers: for a clamped vector the quotient never exceeds the input magnitude.
  for (genvar i = 0; i < Steps; i++) begin : g_div
    localparam int J = Steps - 1 - i;
    logic [63:0] dsh;
    vmc_slot_t   nxt;
    always_comb begin
      dsh = 64'(dv[i].root) << J;
      nxt = dv[i];
      if (dv[i].nx >= dsh) begin
        nxt.nx    = dv[i].nx - dsh;
        nxt.qx[J] = 1'b1;
      end
      if (dv[i].ny >= dsh) begin
        nxt.ny    = dv[i].ny - dsh;
        nxt.qy[J] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1].valid <= 1'b0;
      end else begin
        dv[i+1].valid <= dv[i].valid;
      end
      dv[i+1].xr    <= nxt.xr;
      dv[i+1].yr    <= nxt.yr;
      dv[i+1].clamp <= nxt.clamp;
      dv[i+1].rem   <= nxt.rem;
      dv[i+1].root  <= nxt.root;
      dv[i+1].nx    <= nxt.nx;
      dv[i+1].ny    <= nxt.ny;
      dv[i+1].qx    <= nxt.qx;
      dv[i+1].qy    <= nxt.qy;
    end
  end

  logic [31:0] xs, ys;
  assign xs = dv[Steps].xr[31] ? 32'(-dv[Steps].qx) : dv[Steps].qx;
  assign ys = dv[Steps].yr[31] ? 32'(-dv[Steps].qy) : dv[Steps].qy;

  assign done           = dv[Steps].valid;
  assign result.x_out   = dv[Steps].clamp ? xs : dv[Steps].xr;
  assign result.y_out   = dv[Steps].clamp ? ys : dv[Steps].yr;
  assign result.clamped = dv[Steps].clamp;

endmodule

// File: verif/tb_vector_magnitude_clamp_2d.sv
// Testbench for the 2-D vector length clamp: directed and random vectors
// are driven through the command handshake and each strobed result is
// checked against an in-bench integer model. Depends on vmc_pkg and the RTL.
module tb_vector_magnitude_clamp_2d;
  timeunit 1ns;
  timeprecision 1ps;
  import vmc_pkg::*;

  localparam int LATENCY = 67;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  vmc_in_t in_item = '0;
  vmc_out_t result;

  vector_magnitude_clamp_2d dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_item(in_item), .done(done), .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  vmc_in_t  pending_vectors[$];
  vmc_out_t clamp_expected[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  bit drain_request = 1'b0;
  bit stim_done = 1'b0;

  function automatic logic [63:0] abs_of(logic [31:0] raw);
    logic [31:0] n;
    begin
      n = raw[31] ? (~raw + 32'd1) : raw;
      return {32'd0, n};
    end
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    begin
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    end
  endfunction

  function automatic logic [31:0] rescale(logic [31:0] raw, logic [63:0] lim,
                                          logic [63:0] root);
    logic [63:0] q;
    logic [31:0] r;
    begin
      q = (abs_of(raw) * lim) / root;
      r = q[31:0];
      if (raw[31]) r = ~r + 32'd1;
      return r;
    end
  endfunction

  function automatic vmc_out_t clamp_vector(vmc_in_t v);
    vmc_out_t o;
    logic [63:0] mx, my, sum, lim, root;
    begin
      mx = abs_of(v.x_in);
      my = abs_of(v.y_in);
      sum = mx * mx + my * my;
      lim = {33'd0, v.limit};
      o.x_out = v.x_in;
      o.y_out = v.y_in;
      o.clamped = 1'b0;
      if (sum > lim * lim) begin
        root = floor_sqrt(sum);
        if (root != 0) begin
          o.x_out = rescale(v.x_in, lim, root);
          o.y_out = rescale(v.y_in, lim, root);
          o.clamped = 1'b1;
        end
      end
      return o;
    end
  endfunction

  function automatic int gap_length();
    begin
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
      return 0;
    end
  endfunction

  function automatic logic [31:0] rand_comp();
    logic [31:0] c;
    begin
      case ($urandom_range(0, 5))
        0: c = $urandom();
        1: c = $urandom_range(0, 32'h0003_FFFF);
        2: c = -$urandom_range(0, 32'h0003_FFFF);
        3: c = {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
        default: c = $signed($urandom()) >>> $urandom_range(0, 24);
      endcase
      return c;
    end
  endfunction

  function automatic vmc_in_t make_vector(logic [31:0] x, logic [31:0] y,
                                          logic [30:0] lim);
    vmc_in_t v;
    begin
      v.x_in = x;
      v.y_in = y;
      v.limit = lim;
      return v;
    end
  endfunction

  // Driver: a transfer happens at a rising edge with start high and busy low.
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy) clamp_expected.push_back(clamp_vector(in_item));
      if (start && busy) begin
        // keep the current item on the port
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        start <= 1'b0;
      end else if (drain_request && (clamp_expected.size() > 0 || start)) begin
        start <= 1'b0;
      end else if (pending_vectors.size() > 0) begin
        drain_request <= 1'b0;
        in_item <= pending_vectors.pop_front();
        start <= 1'b1;
        hold_off <= gap_length();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Expectations are pushed at the falling edge after acceptance, well
  // before the pipeline can produce the matching result.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (clamp_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", result);
        end else begin
          vmc_out_t e;
          e = clamp_expected.pop_front();
          if (e.x_out !== result.x_out || e.y_out !== result.y_out ||
              e.clamped !== result.clamped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", e, result);
          end
        end
      end
      if (done || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("tb_vector_magnitude_clamp_2d NOT OK");
        $finish;
      end
    end
  end

  initial begin
    pending_vectors.push_back(make_vector(32'd0, 32'd0, 31'd0));
    pending_vectors.push_back(make_vector(32'd1, 32'd0, 31'd0));
    pending_vectors.push_back(make_vector(32'd0, 32'hFFFF_FFFF, 31'd0));
    pending_vectors.push_back(make_vector(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF));
    pending_vectors.push_back(make_vector(32'h8000_0000, 32'h8000_0000, 31'd0));
    pending_vectors.push_back(make_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
    pending_vectors.push_back(make_vector(32'h7FFF_FFFF, 32'h8000_0000, 31'h0001_0000));
    pending_vectors.push_back(make_vector(32'h0003_0000, 32'h0004_0000, 31'h0005_0000));
    pending_vectors.push_back(make_vector(32'h0003_0000, 32'hFFFC_0000, 31'h0004_FFFF));
    pending_vectors.push_back(make_vector(32'hFFFF_FFFD, 32'd4, 31'd1));
    pending_vectors.push_back(make_vector(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'd1));
    pending_vectors.push_back(make_vector(32'd0, 32'h8000_0000, 31'h7FFF_FFFF));
    pending_vectors.push_back(make_vector(32'h5555_5555, 32'hAAAA_AAAA, 31'h2AAA_AAAA));
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    for (int i = 0; i < 900; i++) begin
      logic [30:0] lim;
      case ($urandom_range(0, 3))
        0: lim = 31'($urandom());
        1: lim = 31'($urandom_range(0, 31'h0004_0000));
        2: lim = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
        default: lim = 31'h0000_FFFF << $urandom_range(0, 15);
      endcase
      if (i == 450) begin
        wait (pending_vectors.size() == 0);
        // Set after the driver's own update of the flag has settled.
        @(posedge clk);
        drain_request = 1'b1;
      end
      pending_vectors.push_back(make_vector(rand_comp(), rand_comp(), lim));
      if (pending_vectors.size() > 8) wait (pending_vectors.size() <= 8);
    end
    wait (pending_vectors.size() == 0 && !start);
    @(posedge clk);
    wait (clamp_expected.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && clamp_expected.size() == 0) begin
      $display("tb_vector_magnitude_clamp_2d OK");
    end else begin
      $display("tb_vector_magnitude_clamp_2d NOT OK");
    end
    $finish;
  end
endmodule
